### rtl/substring_split_stream_core_macros.svh
// Assertion macros for the substring split stream core.
`ifndef SUBSTRING_SPLIT_STREAM_CORE_MACROS_SVH
`define SUBSTRING_SPLIT_STREAM_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SSPLIT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssplit assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SSPLIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssplit assertion failed");

`endif

### rtl/ssplit_pkg.sv
// Shared constants, types and helpers of the substring split stream core.
package ssplit_pkg;

   localparam int MAX_SEPARATOR_BYTES = 16;
   localparam int POSITION_BITS       = 16;

   // usable separator length never exceeds the 16 configured bytes
   localparam int SEP_CAP      = (MAX_SEPARATOR_BYTES < 16) ? MAX_SEPARATOR_BYTES : 16;
   localparam int SEP_CNT_BITS = $clog2(SEP_CAP + 1);
   localparam int FIELD_BITS   = 16;
   localparam int SEP_BITS     = 128;

   localparam logic [FIELD_BITS-1:0] COUNT_MAX = {FIELD_BITS{1'b1}};
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEP_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEP_HIGH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEP_LEN  = 2'd2;

   // request kinds
   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_END  = 1'b1;

   typedef logic [7:0] byte_type;
   typedef logic [SEP_CNT_BITS-1:0] sep_cnt_type;
   typedef logic [POSITION_BITS-1:0] pos_type;

   typedef struct packed {
      logic                  overflow;
      logic                  last;
      logic [FIELD_BITS-1:0] count;
      logic [FIELD_BITS-1:0] length;
      logic [FIELD_BITS-1:0] start;
   } result_type;

   // separator byte that window entry k must equal for an active length n
   function automatic byte_type sep_pick(logic [SEP_BITS-1:0] sep, sep_cnt_type n, int k);
      logic [4:0] idx;
      idx = 5'(int'(n) - 1 - k);
      return sep[{idx[3:0], 3'b000} +: 8];
   endfunction

endpackage

### rtl/ssplit_cell.sv
// One window cell: holds a byte, compares the incoming byte, extends the match chain.
module ssplit_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  ssplit_pkg::byte_type byte_in,
   input  ssplit_pkg::byte_type sep_byte,
   input  logic                active,
   input  logic                chain_in,
   output ssplit_pkg::byte_type byte_out,
   output logic                chain_out
);

   ssplit_pkg::byte_type byte_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   // compare against the byte this cell will hold after the shift
   assign chain_out = chain_in & (~active | (byte_in == sep_byte));
   assign byte_out  = byte_ff;

endmodule

### rtl/ssplit_skid.sv
// Output register with a skid entry for the result channel.
module ssplit_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ssplit_pkg::result_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ssplit_pkg::result_type out_data
);

   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   ssplit_pkg::result_type out_data_ff, out_data_in;
   ssplit_pkg::result_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

### rtl/substring_split_stream_core.sv
// Top level: splits a byte stream into tokens at a configured separator.
// A closing byte or end beat's result is registered to rsp_, via the skid entry when stalled.
// Throughput: one req beat per cycle while req_tready is high; all cells compare in that cycle.
// A stalled rsp_ side holds one result in a skid entry; req_tready drops only when it is full.
// Reset (synchronous, active high) clears view state and sets the separator to one zero byte.
module substring_split_stream_core (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_we,
   input  logic [ssplit_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0] csr_wdata,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] token_start, [31:16] token_length,
                                    // [47:32] separator_count
   output logic        rsp_tlast,   // last_token
   output logic        rsp_tuser    // [0] length_overflow
);

   localparam int P = ssplit_pkg::POSITION_BITS;
   localparam int C = ssplit_pkg::SEP_CAP;

   // configuration registers
   logic [63:0] sep_low_ff, sep_high_ff;
   logic [4:0]  sep_len_ff;

   // view state
   ssplit_pkg::pos_type     pos_ff, pos_in;
   ssplit_pkg::pos_type     start_ff, start_in;
   ssplit_pkg::sep_cnt_type since_ff, since_in;
   logic [ssplit_pkg::FIELD_BITS-1:0] count_ff, count_in;
   logic                    ovf_ff, ovf_in;

   logic                    accept, is_data, is_end;
   ssplit_pkg::sep_cnt_type act_len;
   logic [ssplit_pkg::SEP_BITS-1:0] sep_all;
   logic                    hit;
   logic                    res_valid;
   ssplit_pkg::result_type  res_data, out_data;
   logic                    skid_ready;

   // cell chain wiring
   ssplit_pkg::byte_type    cell_in  [C];
   ssplit_pkg::byte_type    cell_out [C];
   logic                    chain    [C+1];

   // position arithmetic
   ssplit_pkg::pos_type     pos_step;
   logic [P:0]              match_base;
   ssplit_pkg::pos_type     match_len, end_len;

   assign accept  = req_tvalid & req_tready;
   assign is_data = (req_tuser == ssplit_pkg::REQ_DATA);
   assign is_end  = (req_tuser == ssplit_pkg::REQ_END);
   assign sep_all = {sep_high_ff, sep_low_ff};

   // length zero acts as one, lengths past the cap are clamped
   always_comb begin
      if (sep_len_ff == 5'd0) begin
         act_len = ssplit_pkg::SEP_CNT_BITS'(1);
      end else if (int'(sep_len_ff) > C) begin
         act_len = ssplit_pkg::SEP_CNT_BITS'(C);
      end else begin
         act_len = ssplit_pkg::SEP_CNT_BITS'(sep_len_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_low_ff  <= '0;
         sep_high_ff <= '0;
         sep_len_ff  <= 5'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            ssplit_pkg::CSR_SEP_LOW:  sep_low_ff  <= csr_wdata;
            ssplit_pkg::CSR_SEP_HIGH: sep_high_ff <= csr_wdata;
            ssplit_pkg::CSR_SEP_LEN:  sep_len_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // window cells: cell 0 takes the new byte, each later cell its neighbor's
   assign chain[0] = 1'b1;
   for (genvar k = 0; k < C; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign cell_in[k] = req_tdata;
      end else begin : g_body
         assign cell_in[k] = cell_out[k-1];
      end
      ssplit_cell u_cell (
         .clock     (clock),
         .shift_en  (accept & is_data),
         .byte_in   (cell_in[k]),
         .sep_byte  (ssplit_pkg::sep_pick(sep_all, act_len, k)),
         .active    (k < int'(act_len)),
         .chain_in  (chain[k]),
         .byte_out  (cell_out[k]),
         .chain_out (chain[k+1])
      );
   end

   assign pos_step = (pos_ff < ssplit_pkg::POS_MAX) ? pos_ff + 1'b1 : pos_ff;
   assign since_in = (int'(since_ff) < C) ? since_ff + 1'b1 : since_ff;

   // only a window filled since the token opened may match
   assign hit = chain[C] & (since_in >= act_len);

   // token ends n bytes before the current position, floored at zero
   assign match_base = {1'b0, start_ff} + (P+1)'(act_len);
   assign match_len  = ({1'b0, pos_step} >= match_base)
                     ? P'({1'b0, pos_step} - match_base) : '0;
   assign end_len    = (pos_ff > start_ff) ? pos_ff - start_ff : '0;

   always_comb begin
      pos_in    = pos_ff;
      start_in  = start_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      res_valid = 1'b0;
      res_data  = '0;
      if (accept) begin
         if (is_end) begin
            res_valid       = 1'b1;
            res_data.start  = ssplit_pkg::FIELD_BITS'(start_ff);
            res_data.length = ssplit_pkg::FIELD_BITS'(end_len);
            res_data.last   = 1'b1;
            res_data.count  = count_ff;
            res_data.overflow = ovf_ff;
            pos_in   = '0;
            start_in = '0;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            pos_in = pos_step;
            ovf_in = ovf_ff | (pos_ff == ssplit_pkg::POS_MAX);
            if (hit) begin
               count_in  = (count_ff != ssplit_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;
               res_valid = 1'b1;
               res_data.start    = ssplit_pkg::FIELD_BITS'(start_ff);
               res_data.length   = ssplit_pkg::FIELD_BITS'(match_len);
               res_data.last     = 1'b0;
               res_data.count    = count_in;
               res_data.overflow = ovf_in;
               start_in = pos_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         since_ff <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (accept) begin
            // a match or end of view restarts the byte count since the token opened
            if (is_end || hit) begin
               since_ff <= '0;
            end else begin
               since_ff <= since_in;
            end
         end
      end
   end

   ssplit_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (skid_ready),
      .in_data   (res_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign req_tready = skid_ready;
   assign rsp_tdata  = {out_data.count, out_data.length, out_data.start};
   assign rsp_tlast  = out_data.last;
   assign rsp_tuser  = out_data.overflow;

endmodule

### rtl/ssplit_checker.sv
// Port-level checks for the substring split stream core, bound to the top level.
`include "substring_split_stream_core_macros.svh"

module ssplit_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // a stalled result stays offered
   `SSPLIT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // a stalled result keeps its payload
   `SSPLIT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // nothing is offered right after reset
   `SSPLIT_ASSERT_SAME(a_reset_idle, clock, reset, $past(reset), !rsp_tvalid)

   // a token closed by a separator always comes with a nonzero match count
   `SSPLIT_ASSERT_SAME(a_mid_count, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[47:32] != 16'd0)

   // with no match in the view the final token starts at offset zero
   `SSPLIT_ASSERT_SAME(a_end_start, clock, reset, rsp_tvalid && rsp_tlast && (rsp_tdata[47:32] == 16'd0), rsp_tdata[15:0] == 16'd0)

endmodule

bind substring_split_stream_core ssplit_checker u_ssplit_checker (.*);

### tb/substring_split_stream_core_tb.sv
// Self-checking testbench for the substring split stream core.
module substring_split_stream_core_tb;

   localparam int IDLE_LIMIT  = 2000;  // cycles without any beat or register write before giving up
   localparam int DRAIN_WAIT  = 4;     // extra wait after the last result drains, before registers change
   localparam int PHASE_ITEMS = 65;
   localparam int PHASES      = 8;

   typedef struct packed {
      logic                 kind;
      ssplit_pkg::byte_type data;
   } req_item_type;

   logic                                  clock      = 1'b0;
   logic                                  reset      = 1'b1;
   logic                                  csr_we     = 1'b0;
   logic [ssplit_pkg::CSR_INDEX_BITS-1:0] csr_index  = ssplit_pkg::CSR_SEP_LOW;
   logic [63:0]                           csr_wdata  = '0;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [7:0]                            req_tdata  = '0;   // [7:0] data_byte
   logic                                  req_tuser  = 1'b0; // [0] req_type
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [47:0]                           rsp_tdata;  // [15:0] start, [31:16] length,
                                                      // [47:32] count
   logic                                  rsp_tlast;  // last_token
   logic                                  rsp_tuser;  // [0] length_overflow

   substring_split_stream_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: separator registers and per-view state, kept in step with
   // the block by updating on the same edges the block sees.
   // ---------------------------------------------------------------------
   logic [127:0] cfg_sep = '0;   // separator byte k in bits 8k+7:8k
   logic [4:0]   cfg_len = 5'd1;

   ssplit_pkg::byte_type window [16] = '{default: '0};  // entry 0 is the newest byte
   int unsigned view_pos      = 0;
   int unsigned token_open    = 0;
   int unsigned bytes_open    = 0;
   int unsigned match_count   = 0;
   logic        overflow_flag = 1'b0;

   ssplit_pkg::result_type token_q [$];  // tokens the block still owes us
   req_item_type           pending [$];  // beats waiting for the driver

   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  req_took = 1'b0;
   int  req_wait = 0;
   int  req_calm = 0;
   int  rsp_stall = 0;
   int  rsp_calm = 0;

   // Advance the predictor by one accepted request beat; returns 1 when the
   // beat closes a token.
   function automatic bit split_step(input logic kind, input ssplit_pkg::byte_type b,
                                     output ssplit_pkg::result_type tok);
      int unsigned n;
      int unsigned k;
      tok = '0;
      // zero length acts as 1, anything past the cap is clamped
      n = (cfg_len == 0) ? 1 : ((cfg_len > ssplit_pkg::SEP_CAP) ? ssplit_pkg::SEP_CAP
                                                                 : cfg_len);
      if (kind == ssplit_pkg::REQ_END) begin
         tok.start    = 16'(token_open);
         tok.length   = (view_pos > token_open) ? 16'(view_pos - token_open) : '0;
         tok.last     = 1'b1;
         tok.count    = 16'(match_count);
         tok.overflow = overflow_flag;
         for (k = 0; k < 16; k++) window[k] = '0;
         view_pos      = 0;
         token_open    = 0;
         bytes_open    = 0;
         match_count   = 0;
         overflow_flag = 1'b0;
         return 1'b1;
      end
      for (k = 15; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      // position sticks at the top once the range is used up
      if (view_pos < ssplit_pkg::POS_MAX) view_pos++;
      else overflow_flag = 1'b1;
      if (bytes_open < ssplit_pkg::SEP_CAP) bytes_open++;
      // need a full separator worth of bytes since the token opened
      if (bytes_open < n) return 1'b0;
      // newest byte must equal the last separator byte, and so on back
      for (k = 0; k < n; k++)
         if (window[k] !== cfg_sep[8*(n-1-k) +: 8]) return 1'b0;
      if (match_count < ssplit_pkg::COUNT_MAX) match_count++;
      tok.start    = 16'(token_open);
      // saturated positions can leave the separator overlapping the start
      tok.length   = (view_pos >= n + token_open) ? 16'(view_pos - n - token_open) : '0;
      tok.last     = 1'b0;
      tok.count    = 16'(match_count);
      tok.overflow = overflow_flag;
      token_open   = view_pos;
      bytes_open   = 0;
      return 1'b1;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a calm stretch.
   function automatic int next_gap(inout int calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if (r < 3) begin
         calm = $urandom_range(40, 150);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: holds a beat until it is taken, then either idles
   // for a while or presents the next queued beat.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      req_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_took) begin
         // beat still waiting for req_tready
      end else if (req_wait > 0) begin
         req_wait--;
         req_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
         item = pending.pop_front();
         req_tvalid <= 1'b1;
         req_tuser  <= item.kind;
         req_tdata  <= item.data;
         req_wait   = next_gap(req_calm);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Result side backpressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 30) rsp_stall = next_gap(rsp_calm);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: tracks register writes, predicts on each request beat and
   // checks each result beat against the oldest predicted token.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      ssplit_pkg::result_type tok;
      ssplit_pkg::result_type got;
      bit                     rsp_took;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               ssplit_pkg::CSR_SEP_LOW:  cfg_sep[63:0]   = csr_wdata;
               ssplit_pkg::CSR_SEP_HIGH: cfg_sep[127:64] = csr_wdata;
               ssplit_pkg::CSR_SEP_LEN:  cfg_len         = csr_wdata[4:0];
               default: ;
            endcase
         end
         req_took = req_tvalid && req_tready;
         if (req_took && split_step(req_tuser, req_tdata, tok)) token_q.push_back(tok);
         rsp_took = rsp_tvalid && rsp_tready;
         if (rsp_took) begin
            got.start    = rsp_tdata[15:0];
            got.length   = rsp_tdata[31:16];
            got.count    = rsp_tdata[47:32];
            got.last     = rsp_tlast;
            got.overflow = rsp_tuser;
            if (token_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: start=%0d len=%0d last=%0b count=%0d ovf=%0b",
                           got.start, got.length, got.last, got.count, got.overflow);
            end else begin
               tok = token_q.pop_front();
               if (got !== tok) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("token mismatch: exp start=%0d len=%0d last=%0b count=%0d ovf=%0b",
                              tok.start, tok.length, tok.last, tok.count, tok.overflow);
                     $display("                got start=%0d len=%0d last=%0b count=%0d ovf=%0b",
                              got.start, got.length, got.last, got.count, got.overflow);
                  end
               end
            end
         end
         // watchdog: any beat or register write counts as progress
         if (req_took || rsp_took || csr_we) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic push_req(input logic kind, input ssplit_pkg::byte_type b);
      pending.push_back({kind, b});
   endtask

   // Registers change only with nothing in flight.
   task automatic settle();
      while (pending.size() != 0 || req_tvalid || token_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ssplit_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [63:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [127:0]         pat;
      logic [4:0]           len_cfg;
      ssplit_pkg::byte_type sym_a, sym_b;
      int                   n, r, j, k, m, ph, count, view_len;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset separator is a single zero byte.
      push_req(ssplit_pkg::REQ_END, 8'hA5);    // empty view: start 0, length 0
      push_req(ssplit_pkg::REQ_DATA, 8'h00);   // match right at the start, empty token
      push_req(ssplit_pkg::REQ_DATA, 8'hFF);   // no match
      push_req(ssplit_pkg::REQ_DATA, 8'h00);   // token of one byte
      push_req(ssplit_pkg::REQ_END, 8'h5A);    // empty final token
      settle();

      // Oversized length clamps to 16; all-ones separator.
      write_csr(ssplit_pkg::CSR_SEP_LOW, '1);
      write_csr(ssplit_pkg::CSR_SEP_HIGH, '1);
      write_csr(ssplit_pkg::CSR_SEP_LEN, 64'd31);
      push_req(ssplit_pkg::REQ_DATA, 8'h00);
      for (k = 0; k < 16; k++) push_req(ssplit_pkg::REQ_DATA, 8'hFF);
      push_req(ssplit_pkg::REQ_END, 8'hFF);
      settle();

      // Length zero behaves as one byte.
      write_csr(ssplit_pkg::CSR_SEP_LEN, 64'd0);
      push_req(ssplit_pkg::REQ_DATA, 8'hFF);
      push_req(ssplit_pkg::REQ_END, 8'h00);

      // Random phases: new separator each time, views built largely from
      // separator bytes so matches, partial matches and overlaps are common.
      for (ph = 0; ph < PHASES; ph++) begin
         sym_a = 8'($urandom);
         sym_b = 8'($urandom);
         for (k = 0; k < 16; k++)
            pat[8*k +: 8] = ($urandom_range(0, 9) < 7) ?
                            ($urandom_range(0, 1) ? sym_a : sym_b) : 8'($urandom);
         r = $urandom_range(0, 99);
         if (r < 50)      len_cfg = 5'($urandom_range(1, 3));
         else if (r < 75) len_cfg = 5'($urandom_range(4, 8));
         else if (r < 85) len_cfg = 5'd16;
         else if (r < 90) len_cfg = 5'd0;
         else if (r < 95) len_cfg = 5'($urandom_range(17, 31));
         else             len_cfg = 5'($urandom_range(9, 15));
         n = (len_cfg == 0) ? 1 : ((len_cfg > 16) ? 16 : int'(len_cfg));
         settle();
         write_csr(ssplit_pkg::CSR_SEP_LOW, pat[63:0]);
         write_csr(ssplit_pkg::CSR_SEP_HIGH, pat[127:64]);
         write_csr(ssplit_pkg::CSR_SEP_LEN, 64'(len_cfg));
         count = 0;
         while (count < PHASE_ITEMS) begin
            view_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                   : $urandom_range(3, 40);
            j = 0;
            while (j < view_len) begin
               r = $urandom_range(0, 99);
               if (r < 35) begin
                  // whole separator
                  for (k = 0; k < n; k++) push_req(ssplit_pkg::REQ_DATA, pat[8*k +: 8]);
                  j += n;
               end else if (r < 45) begin
                  // separator prefix that may stop short
                  m = $urandom_range(1, n);
                  for (k = 0; k < m; k++) push_req(ssplit_pkg::REQ_DATA, pat[8*k +: 8]);
                  j += m;
               end else if (r < 80) begin
                  push_req(ssplit_pkg::REQ_DATA, $urandom_range(0, 1) ? sym_a : sym_b);
                  j++;
               end else begin
                  push_req(ssplit_pkg::REQ_DATA, 8'($urandom));
                  j++;
               end
            end
            count += j;
            // now and then leave the view open across a register change
            if (ph == PHASES - 1 || $urandom_range(0, 5) != 0) begin
               push_req(ssplit_pkg::REQ_END, 8'($urandom));
               count++;
            end
         end
      end

      // Short tail after the last view: state must be clean again.
      for (k = 0; k < 20; k++)
         push_req(ssplit_pkg::REQ_DATA, $urandom_range(0, 1) ? sym_a : 8'($urandom));
      push_req(ssplit_pkg::REQ_END, 8'($urandom));

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && token_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
